/* design/spd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Selective percent decoder package
// Shared types, character codes and character class functions.
// ----------------------------------------------------------------------------
package spd_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned MAX_OUT   = 3;
    localparam int unsigned CNT_W     = 2;

    localparam logic [BYTE_W-1:0] C_PERCENT = 8'h25;
    localparam logic [BYTE_W-1:0] C_PLUS    = 8'h2B;
    localparam logic [BYTE_W-1:0] C_SPACE   = 8'h20;

    // Escape tracking state.
    typedef enum logic [2:0] {
        PEND_NONE  = 3'b001,
        PEND_PCT   = 3'b010,
        PEND_DIGIT = 3'b100
    } t_pend;

    // Result bytes produced by one input byte.
    typedef struct packed {
        logic [CNT_W-1:0]                count;
        logic [MAX_OUT-1:0][BYTE_W-1:0]  bytes;
        logic                            last;
    } t_group;

    function automatic logic is_hex(input logic [BYTE_W-1:0] c);
        return (c >= 8'd48 && c <= 8'd57) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic [3:0] hex_val(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] d;
        d = 8'd0;
        if (c >= 8'd48 && c <= 8'd57) begin
            d = c - 8'd48;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = c - 8'h61 + 8'd10;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = c - 8'h41 + 8'd10;
        end
        return d[3:0];
    endfunction

    function automatic logic is_safe(input logic [BYTE_W-1:0] v);
        return (v >= 8'd48 && v <= 8'd57) || (v >= 8'd97 && v <= 8'd122) ||
               (v >= 8'd65 && v <= 8'd90) || (v >= 8'h26 && v <= 8'h2f) ||
               v == 8'h21 || v == 8'h24 || v == 8'h3A || v == 8'h3B ||
               v == 8'h3D || v == 8'h3f || v == 8'h40 || v == 8'h5f;
    endfunction

endpackage
`default_nettype wire

/* design/spd_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Selective percent decoder stream interfaces
// Valid/ready channels for encoded input bytes and decoded output bytes.
// ----------------------------------------------------------------------------
interface spd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface spd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface
`default_nettype wire

/* design/spd_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Selective percent decoder core
// Escape state and the decode of one byte into up to three result bytes.
// ----------------------------------------------------------------------------
module spd_core
    import spd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire logic [BYTE_W-1:0] i_byte,
    input  wire logic              i_last,
    output t_group                 o_group
);

    t_pend             r_pend, n_pend;
    logic [BYTE_W-1:0] r_first, n_first;

    always_comb begin
        logic             plain;
        logic [CNT_W-1:0] idx;
        logic [BYTE_W-1:0] v;
        t_pend            mid;

        plain   = 1'b1;
        idx     = '0;
        v       = {hex_val(r_first), hex_val(i_byte)};
        mid     = PEND_NONE;
        n_first = r_first;
        o_group = '0;

        unique case (r_pend)
            PEND_DIGIT: begin
                if (is_hex(i_byte)) begin
                    if (is_safe(v)) begin
                        o_group.bytes[idx] = C_PERCENT; idx = idx + 2'd1;
                        o_group.bytes[idx] = r_first;   idx = idx + 2'd1;
                        o_group.bytes[idx] = i_byte;    idx = idx + 2'd1;
                    end else begin
                        o_group.bytes[idx] = v;         idx = idx + 2'd1;
                    end
                    plain = 1'b0;
                end else begin
                    o_group.bytes[idx] = C_PERCENT; idx = idx + 2'd1;
                    o_group.bytes[idx] = r_first;   idx = idx + 2'd1;
                end
            end
            PEND_PCT: begin
                if (is_hex(i_byte)) begin
                    n_first = i_byte;
                    mid     = PEND_DIGIT;
                    plain   = 1'b0;
                end else begin
                    o_group.bytes[idx] = C_PERCENT; idx = idx + 2'd1;
                end
            end
            default: begin
            end
        endcase

        if (plain) begin
            if (i_byte == C_PLUS) begin
                o_group.bytes[idx] = C_SPACE; idx = idx + 2'd1;
            end else if (i_byte == C_PERCENT) begin
                mid = PEND_PCT;
            end else begin
                o_group.bytes[idx] = i_byte; idx = idx + 2'd1;
            end
        end

        n_pend = mid;
        if (i_last) begin
            if (mid == PEND_PCT) begin
                o_group.bytes[idx] = C_PERCENT; idx = idx + 2'd1;
            end else if (mid == PEND_DIGIT) begin
                o_group.bytes[idx] = C_PERCENT; idx = idx + 2'd1;
                o_group.bytes[idx] = n_first;   idx = idx + 2'd1;
            end
            n_pend  = PEND_NONE;
            n_first = '0;
        end

        o_group.count = idx;
        o_group.last  = i_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= PEND_NONE;
            r_first <= '0;
        end else if (i_accept) begin
            r_pend  <= n_pend;
            r_first <= n_first;
        end
    end

endmodule
`default_nettype wire

/* design/spd_outbuf.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Selective percent decoder output buffer
// Holds the result bytes of one input byte and sends them one per transfer.
// ----------------------------------------------------------------------------
module spd_outbuf
    import spd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire t_group            i_group,
    input  wire logic              i_out_ready,
    output logic                   o_in_ready,
    output logic                   o_valid,
    output logic [BYTE_W-1:0]      o_byte,
    output logic                   o_last
);

    logic [CNT_W-1:0]               r_cnt;
    logic [MAX_OUT-1:0][BYTE_W-1:0] r_bytes;
    logic                           r_last;
    logic                           take;

    assign o_valid    = (r_cnt != '0);
    assign take       = o_valid && i_out_ready;
    assign o_in_ready = (r_cnt == '0) || (r_cnt == 2'd1 && i_out_ready);
    assign o_byte     = r_bytes[0];
    assign o_last     = r_last && (r_cnt == 2'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_group.count;
        end else if (take) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes <= i_group.bytes;
            r_last  <= i_group.last;
        end else if (take) begin
            r_bytes <= {{BYTE_W{1'b0}}, r_bytes[MAX_OUT-1:1]};
        end
    end

endmodule
`default_nettype wire

/* design/selective_percent_decoder_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Selective percent decoder top level
// Timing: the first result of a byte is offered in the cycle after its transfer.
// Throughput: one byte per cycle while the output is ready and each byte gives at most one result;
// a byte giving more results holds the input until its last result is taken at the single output port.
// Reset: synchronous active low; clears escape state and drops buffered results.
// ----------------------------------------------------------------------------
module selective_percent_decoder_top
    import spd_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    spd_in_if.sink     i_in,
    spd_out_if.source  o_out
);

    t_group group;
    logic   in_ready;
    logic   accept;

    assign i_in.ready = in_ready;
    assign accept     = i_in.valid && in_ready;

    spd_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_in.in_byte),
        .i_last   (i_in.in_last),
        .o_group  (group)
    );

    spd_outbuf u_outbuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept),
        .i_group     (group),
        .i_out_ready (o_out.ready),
        .o_in_ready  (in_ready),
        .o_valid     (o_out.valid),
        .o_byte      (o_out.out_byte),
        .o_last      (o_out.out_last)
    );

endmodule
`default_nettype wire
